// ===== rtl/kpt_pkg.sv =====
// Shared types, operation and status codes, and key helper for the keyed point table.
package kpt_pkg;

  localparam int unsigned COORD_W = 24;
  localparam int unsigned KEY_W   = 16;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned ST_W    = 3;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned CNT_W   = 11;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
  localparam logic [OP_W-1:0] OP_RM_KEY  = 3'd1;
  localparam logic [OP_W-1:0] OP_RM_WIN  = 3'd2;
  localparam logic [OP_W-1:0] OP_RM_POS  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ    = 3'd4;

  // Status codes
  localparam logic [ST_W-1:0] ST_DONE     = 3'd0;
  localparam logic [ST_W-1:0] ST_DUP      = 3'd1;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
  localparam logic [ST_W-1:0] ST_RANGE    = 3'd4;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic key_hit;
    logic win_hit;
  } match_t;

  // Integer part of a Q15.8 value, truncated toward zero
  function automatic logic [KEY_W-1:0] int_part(input logic [COORD_W-1:0] v);
    logic [KEY_W-1:0] q;
    q = v[COORD_W-1:8];
    if (v[COORD_W-1] && (v[7:0] != 8'd0)) begin
      q = q + 16'd1;
    end
    return q;
  endfunction

endpackage

// ===== rtl/keyed_point_table.sv =====
// Top level: request sequencer, entry count, result register and checks.
//
// Packed table of Q15.8 points keyed by the integer parts of x and z.
// Requests enter on the in channel (in_valid_i / in_stall_o); each gives
// exactly one result on the out channel (out_valid_o / out_stall_i).
// A request is taken only while the sequencer is idle; in_stall_o is high
// for the whole of its work. Timing is set by the single memory read port,
// which visits one entry per cycle:
//   insert, remove by key, remove in window: key search of up to count
//     entries; a removal then compacts the entries above the hit, one
//     per cycle.
//   remove at position: compacts the entries above that position.
//   read at position: one memory read; out-of-range or unused codes go
//     straight to the result.
// The finished result sits in an output register: a new request is taken
// while it waits, and the next result is held back until it is taken.
// A stalled result holds its value. Reset empties the table at once (count
// to zero, no clearing pass) and drops any pending result.
module keyed_point_table import kpt_pkg::*; #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [OP_W-1:0]           op_i,
  input  logic signed [COORD_W-1:0] coord_x_i,
  input  logic signed [COORD_W-1:0] coord_y_i,
  input  logic signed [COORD_W-1:0] coord_z_i,
  input  logic signed [COORD_W-1:0] height_low_i,
  input  logic signed [COORD_W-1:0] height_high_i,
  input  logic [IDX_W-1:0]          entry_index_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [ST_W-1:0]           status_o,
  output logic [CNT_W-1:0]          count_now_o,
  output logic signed [COORD_W-1:0] read_x_o,
  output logic signed [COORD_W-1:0] read_y_o,
  output logic signed [COORD_W-1:0] read_z_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > IDX_W) ? CW : IDX_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_READ   = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      ptr_q, ptr_d;
  logic               vld_q, vld_d;
  logic [AW-1:0]      slot_q, slot_d;
  logic [AW-1:0]      wr_q, wr_d;

  logic [OP_W-1:0]    op_q;
  logic [COORD_W-1:0] x_q, y_q, z_q, hlo_q, hhi_q;
  logic [IDX_W-1:0]   idx_q;

  logic [ST_W-1:0]    res_status_q, res_status_d;
  point_t             res_pt_q, res_pt_d;

  logic               out_valid_q, out_valid_d;
  logic [ST_W-1:0]    out_status_q;
  logic [CNT_W-1:0]   out_count_q;
  point_t             out_pt_q;

  logic               accept;
  logic               issue;
  logic               hit;
  logic               load_out;
  logic               idx_in_range;
  logic [CW-1:0]      idx_cw;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  point_t             mem_wdata;
  point_t             mem_rdata;
  match_t             match;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  // Compare the incoming position against the live count
  assign idx_in_range = XW'(entry_index_i) < XW'(count_q);
  assign idx_cw       = CW'(XW'(entry_index_i));

  // Another entry left to fetch
  assign issue = ptr_q < count_q;

  kpt_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (ptr_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  kpt_match u_match (
    .entry_i       (mem_rdata),
    .req_x_i       (x_q),
    .req_z_i       (z_q),
    .height_low_i  (hlo_q),
    .height_high_i (hhi_q),
    .match_o       (match)
  );

  // Qualify the compare for the current request
  assign hit = vld_q && match.key_hit && ((op_q != OP_RM_WIN) || match.win_hit);

  // Drive the memory write port: compaction move or new entry
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_q;
    mem_wdata = mem_rdata;
    if ((state_q == S_SHIFT) && vld_q) begin
      mem_we = 1'b1;
    end else if ((state_q == S_SCAN) && (op_q == OP_INSERT) && !vld_q && !issue &&
                 (count_q < CAP_C)) begin
      mem_we    = 1'b1;
      mem_waddr = count_q[AW-1:0];
      mem_wdata = '{x: x_q, y: y_q, z: z_q};
    end
  end

  // Sequence one request
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    vld_d        = vld_q;
    slot_d       = slot_q;
    wr_d         = wr_q;
    res_status_d = res_status_q;
    res_pt_d     = res_pt_q;
    load_out     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          vld_d        = 1'b0;
          ptr_d        = '0;
          res_status_d = ST_DONE;
          res_pt_d     = '0;
          case (op_i)
            OP_INSERT, OP_RM_KEY, OP_RM_WIN: begin
              state_d = S_SCAN;
            end
            OP_RM_POS: begin
              if (idx_in_range) begin
                ptr_d   = idx_cw + CW'(1);
                wr_d    = idx_cw[AW-1:0];
                state_d = S_SHIFT;
              end else begin
                res_status_d = ST_RANGE;
                state_d      = S_FINISH;
              end
            end
            OP_READ: begin
              if (idx_in_range) begin
                ptr_d   = idx_cw;
                state_d = S_READ;
              end else begin
                res_status_d = ST_RANGE;
                state_d      = S_FINISH;
              end
            end
            default: begin
              state_d = S_FINISH;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          if (op_q == OP_INSERT) begin
            res_status_d = ST_DUP;
            state_d      = S_FINISH;
          end else begin
            ptr_d   = CW'(slot_q) + CW'(1);
            wr_d    = slot_q;
            vld_d   = 1'b0;
            state_d = S_SHIFT;
          end
        end else if (!vld_q && !issue) begin
          state_d = S_FINISH;
          if (op_q == OP_INSERT) begin
            if (count_q < CAP_C) begin
              count_d = count_q + CW'(1);
            end else begin
              res_status_d = ST_FULL;
            end
          end else begin
            res_status_d = ST_NOTFOUND;
          end
        end else begin
          if (issue) begin
            ptr_d = ptr_q + CW'(1);
          end
          vld_d  = issue;
          slot_d = ptr_q[AW-1:0];
        end
      end

      S_SHIFT: begin
        if (vld_q) begin
          wr_d = wr_q + AW'(1);
        end
        if (!vld_q && !issue) begin
          count_d = count_q - CW'(1);
          state_d = S_FINISH;
        end else begin
          if (issue) begin
            ptr_d = ptr_q + CW'(1);
          end
          vld_d = issue;
        end
      end

      S_READ: begin
        if (vld_q) begin
          res_pt_d = mem_rdata;
          state_d  = S_FINISH;
        end else begin
          vld_d = 1'b1;
        end
      end

      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold a result until taken, then drop it or replace it
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      vld_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request, pointer and result payload
  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    slot_q       <= slot_d;
    wr_q         <= wr_d;
    res_status_q <= res_status_d;
    res_pt_q     <= res_pt_d;
    if (accept) begin
      op_q  <= op_i;
      x_q   <= coord_x_i;
      y_q   <= coord_y_i;
      z_q   <= coord_z_i;
      hlo_q <= height_low_i;
      hhi_q <= height_high_i;
      idx_q <= entry_index_i;
    end
    if (load_out) begin
      out_status_q <= res_status_q;
      out_count_q  <= CNT_W'(count_q);
      out_pt_q     <= res_pt_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign count_now_o = out_count_q;
  assign read_x_o    = out_pt_q.x;
  assign read_y_o    = out_pt_q.y;
  assign read_z_o    = out_pt_q.z;

  // Table never holds more than its capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CAP_C)
    else $error("entry count above capacity");

  // A new result appears only from the finish step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FINISH))
    else $error("result raised outside finish step");

  // Count moves only on an insert or at the end of a compaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> ($past(state_q == S_SCAN) || $past(state_q == S_SHIFT)))
    else $error("entry count changed outside search or compaction");

  // A read at position only starts for a slot that holds an entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (XW'(idx_q) < XW'(count_q)))
    else $error("read started beyond entry count");

endmodule

// ===== rtl/kpt_mem.sv =====
// Point storage: one write port, one registered read port.
module kpt_mem import kpt_pkg::*; #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  point_t        wdata_i,
  input  logic [AW-1:0] raddr_i,
  output point_t        rdata_o
);

  point_t mem_q [DEPTH];
  point_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/kpt_match.sv =====
// Shared compare unit: key equality and inclusive height window test.
module kpt_match import kpt_pkg::*; (
  input  point_t             entry_i,
  input  logic [COORD_W-1:0] req_x_i,
  input  logic [COORD_W-1:0] req_z_i,
  input  logic [COORD_W-1:0] height_low_i,
  input  logic [COORD_W-1:0] height_high_i,
  output match_t             match_o
);

  // Compare truncated integer parts of x and z
  assign match_o.key_hit = (int_part(entry_i.x) == int_part(req_x_i)) &&
                           (int_part(entry_i.z) == int_part(req_z_i));

  // Check stored height against the window, both bounds inclusive
  assign match_o.win_hit = ($signed(entry_i.y) >= $signed(height_low_i)) &&
                           ($signed(entry_i.y) <= $signed(height_high_i));

endmodule
